@@ rtl/core/number_to_lcd_segment_writes_unit_macros.svh @@
`ifndef NUMBER_TO_LCD_SEGMENT_WRITES_UNIT_MACROS_SVH
`define NUMBER_TO_LCD_SEGMENT_WRITES_UNIT_MACROS_SVH

// Antecedent in one cycle implies consequent in the same cycle.
`define NLSW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlsw assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define NLSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlsw assertion failed");

`endif

@@ rtl/core/nlsw_pkg.sv @@
package nlsw_pkg;

  localparam int DIGIT_COUNT = 6;
  localparam int MEM_BYTES = 21;
  localparam int POSITIONS = 6;
  localparam int DIGIT_LIMIT = (DIGIT_COUNT < POSITIONS) ? DIGIT_COUNT : POSITIONS;
  localparam int VALUE_BITS = 32;
  localparam int ERR_WRITES = 9;

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_INT = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [4:0] SIGN_OFFSET = 5'd10;
  localparam logic [4:0] POINT_OFFSET = 5'd15;
  localparam logic [7:0] SIGN_BYTE = 8'h04;
  localparam logic [7:0] POINT_BYTE = 8'h01;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0] command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [4:0] mem_offset;
    logic [7:0] mem_data;
    logic last;
  } out_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] r;
    case (d)
      4'd0: r = 8'hFC;
      4'd1: r = 8'h60;
      4'd2: r = 8'hDB;
      4'd3: r = 8'hF3;
      4'd4: r = 8'h67;
      4'd5: r = 8'hB7;
      4'd6: r = 8'hBF;
      4'd7: r = 8'hE4;
      4'd8: r = 8'hFF;
      4'd9: r = 8'hF7;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] digit_offset(input logic [2:0] k);
    logic [4:0] r;
    case (k)
      3'd0: r = 5'd7;
      3'd1: r = 5'd14;
      3'd2: r = 5'd18;
      3'd3: r = 5'd3;
      3'd4: r = 5'd5;
      3'd5: r = 5'd9;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] err_offset(input logic [3:0] i);
    logic [4:0] r;
    case (i)
      4'd0: r = 5'd2;
      4'd1: r = 5'd9;
      4'd2: r = 5'd5;
      4'd3: r = 5'd6;
      4'd4: r = 5'd3;
      4'd5: r = 5'd4;
      4'd6: r = 5'd18;
      4'd7: r = 5'd14;
      4'd8: r = 5'd15;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] err_data(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h9F;
      4'd2: r = 8'h8E;
      4'd3: r = 8'h22;
      4'd4: r = 8'h8E;
      4'd5: r = 8'h22;
      4'd6: r = 8'hFC;
      4'd7: r = 8'h8E;
      4'd8: r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/number_to_lcd_segment_writes_unit.sv @@
// Turns one display request into a run of segment-memory byte writes.
// The input channel carries a command and a signed value; the output channel
// carries one write (offset, data, last) per transaction, and last marks the
// final write of the request. Both channels use valid and stall.
// A request is taken only when the unit is idle, one request at a time.
// Command 0 clears 21 bytes, then writes sign, point and digits; command 1
// writes sign and digits; command 2 clears and writes 9 error bytes; command 3
// is taken and produces nothing.
// Digits come from a bit-serial divide by ten over all 32 value bits, and
// each digit is then written as one segment byte.
// The output write sits in a register; while the receiver stalls, it holds
// and the sequencer waits before its next write. Reset is synchronous and
// returns the unit to idle with no pending write.
module number_to_lcd_segment_writes_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  nlsw_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output nlsw_pkg::out_t out_item
);
  import nlsw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_POINT = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_DIGIT = 3'd5;
  localparam logic [2:0] S_ERR = 3'd6;

  logic [2:0] state;
  logic [4:0] idx;
  logic [2:0] k;
  logic [31:0] mag;
  logic [3:0] rem;
  logic neg;
  logic point;
  logic err;

  logic slot_free;
  logic send;
  logic mag_zero;
  logic [4:0] trial;
  logic fits;
  logic dig_last;

  assign in_stall = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign send = slot_free && (state == S_CLEAR || state == S_SIGN || state == S_POINT ||
                              state == S_DIGIT || state == S_ERR);
  assign mag_zero = (mag == 32'd0);
  assign trial = {rem, mag[31]};
  assign fits = (trial >= 5'd10);
  assign dig_last = mag_zero || (k == 3'(DIGIT_LIMIT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (send) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg <= in_item.value[31];
            mag <= in_item.value[31] ? (32'd0 - in_item.value) : in_item.value;
            point <= (in_item.command == CMD_POINT);
            err <= (in_item.command == CMD_ERROR);
            idx <= 5'd0;
            k <= 3'd0;
            rem <= 4'd0;
            case (in_item.command) inside
              CMD_POINT, CMD_ERROR: state <= S_CLEAR;
              CMD_INT: state <= S_SIGN;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          if (slot_free) begin
            out_item <= '{mem_offset: idx, mem_data: BLANK_BYTE, last: 1'b0};
            if (idx == 5'(MEM_BYTES - 1)) begin
              idx <= 5'd0;
              state <= err ? S_ERR : S_SIGN;
            end else begin
              idx <= idx + 5'd1;
            end
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            out_item <= '{mem_offset: SIGN_OFFSET, mem_data: neg ? SIGN_BYTE : BLANK_BYTE,
                          last: !point && mag_zero};
            idx <= 5'd0;
            rem <= 4'd0;
            if (point) begin
              state <= S_POINT;
            end else begin
              state <= mag_zero ? S_IDLE : S_DIV;
            end
          end
        end
        S_POINT: begin
          if (slot_free) begin
            out_item <= '{mem_offset: POINT_OFFSET, mem_data: POINT_BYTE, last: mag_zero};
            state <= mag_zero ? S_IDLE : S_DIV;
          end
        end
        S_DIV: begin
          rem <= fits ? 4'(trial - 5'd10) : trial[3:0];
          mag <= {mag[30:0], fits};
          idx <= idx + 5'd1;
          if (idx == 5'(VALUE_BITS - 1)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (slot_free) begin
            out_item <= '{mem_offset: digit_offset(k), mem_data: seg_code(rem), last: dig_last};
            rem <= 4'd0;
            idx <= 5'd0;
            k <= k + 3'd1;
            state <= dig_last ? S_IDLE : S_DIV;
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_item <= '{mem_offset: err_offset(idx[3:0]), mem_data: err_data(idx[3:0]),
                          last: (idx == 5'(ERR_WRITES - 1))};
            idx <= idx + 5'd1;
            if (idx == 5'(ERR_WRITES - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "number_to_lcd_segment_writes_unit_macros.svh"

  `NLSW_ASSERT_NOW(a_digit_rem_decimal, clk, rst, state == S_DIGIT, rem < 4'd10)
  `NLSW_ASSERT_NOW(a_offset_in_memory, clk, rst, out_valid,
                   out_item.mem_offset < 5'(MEM_BYTES))
  `NLSW_ASSERT_NEXT(a_request_busy, clk, rst,
                    in_valid && !in_stall && (in_item.command != CMD_UNUSED), in_stall)
  `NLSW_ASSERT_NEXT(a_stall_holds_write, clk, rst,
                    out_valid && out_stall, out_valid && $stable(out_item))

endmodule
